/* hw/rtl/hsse_pkg.sv */
package hsse_pkg;

  localparam int unsigned ValW    = 48;
  localparam int unsigned ResW    = 32;
  localparam int unsigned PosW    = 16;
  localparam int unsigned CfgDW   = 32;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] RegSdrSize    = 2'd0;
  localparam logic [CfgIdxW-1:0] RegActiveBits = 2'd1;
  localparam logic [CfgIdxW-1:0] RegResolution = 2'd2;
  localparam logic [CfgIdxW-1:0] RegHashSeed   = 2'd3;

  localparam logic [31:0] MurC1   = 32'hcc9e2d51;
  localparam logic [31:0] MurC2   = 32'h1b873593;
  localparam logic [31:0] MurAdd  = 32'he6546b64;
  localparam logic [31:0] MurLen  = 32'd4;
  localparam logic [31:0] MurFin1 = 32'h85ebca6b;
  localparam logic [31:0] MurFin2 = 32'hc2b2ae35;

  typedef struct packed {
    logic [31:0] index;
    logic        missing;
  } div_res_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] key;
    logic        last;
    logic        empty;
  } hash_req_t;

endpackage

/* hw/rtl/hsse_in_if.sv */
interface hsse_in_if;
  logic                       valid;
  logic                       ready;
  logic [hsse_pkg::ValW-1:0]  value_q16;
  logic                       missing;

  modport source (output valid, output value_q16, output missing, input ready);
  modport sink (input valid, input value_q16, input missing, output ready);
endinterface

/* hw/rtl/hsse_out_if.sv */
interface hsse_out_if;
  logic                       valid;
  logic                       ready;
  logic [hsse_pkg::PosW-1:0]  bit_position;
  logic                       last;
  logic                       empty_res;

  modport source (output valid, output bit_position, output last, output empty_res,
                  input ready);
  modport sink (input valid, input bit_position, input last, input empty_res,
                output ready);
endinterface

/* hw/rtl/hsse_div.sv */
module hsse_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  hsse_in_if.sink                  in_i,
  input  logic [hsse_pkg::ResW-1:0] resolution_i,
  output logic                     res_valid_o,
  output hsse_pkg::div_res_t       res_o,
  input  logic                     res_ready_i
);
  import hsse_pkg::*;

  // Two quotient bits are retired per cycle.
  localparam int unsigned Steps = ValW / 2;
  localparam int unsigned CntW  = $clog2(Steps);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StBusy = 2'd1;
  localparam logic [1:0] StDone = 2'd2;

  logic [1:0]      st_q;
  logic [CntW-1:0] cnt_q;
  logic [ValW-1:0] num_q;
  logic [ResW-1:0] rem_q, quo_q;
  logic            miss_q;
  logic            accept;

  logic [ResW:0]   t0, t1;
  logic [ResW-1:0] r0, r1;
  logic            b0, b1;

  assign in_i.ready = (st_q == StIdle) || ((st_q == StDone) && res_ready_i);
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    t0 = {rem_q, num_q[ValW-1]};
    b0 = t0 >= {1'b0, resolution_i};
    r0 = b0 ? ResW'(t0 - {1'b0, resolution_i}) : t0[ResW-1:0];
    t1 = {r0, num_q[ValW-2]};
    b1 = t1 >= {1'b0, resolution_i};
    r1 = b1 ? ResW'(t1 - {1'b0, resolution_i}) : t1[ResW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= StIdle;
      cnt_q <= '0;
    end else begin
      case (st_q)
        StBusy: begin
          cnt_q <= cnt_q + CntW'(1);
          if (cnt_q == CntW'(Steps - 1)) begin
            st_q <= StDone;
          end
        end
        StDone: begin
          if (res_ready_i && !accept) begin
            st_q <= StIdle;
          end
        end
        default: ;
      endcase
      if (accept) begin
        st_q  <= in_i.missing ? StDone : StBusy;
        cnt_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      num_q  <= in_i.value_q16;
      rem_q  <= '0;
      quo_q  <= '0;
      miss_q <= in_i.missing;
    end else if (st_q == StBusy) begin
      num_q <= {num_q[ValW-3:0], 2'b00};
      rem_q <= r1;
      quo_q <= {quo_q[ResW-3:0], b0, b1};
    end
  end

  assign res_valid_o   = (st_q == StDone);
  assign res_o.index   = quo_q;
  assign res_o.missing = miss_q;

endmodule

/* hw/rtl/hsse_seq.sv */
module hsse_seq #(
  parameter int unsigned MAX_ACTIVE = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               res_valid_i,
  input  hsse_pkg::div_res_t                 res_i,
  output logic                               res_ready_o,
  input  logic [$clog2(MAX_ACTIVE+1)-1:0]    count_i,
  input  logic                               en_i,
  output hsse_pkg::hash_req_t                req_o
);
  import hsse_pkg::*;

  localparam int unsigned CW = $clog2(MAX_ACTIVE + 1);

  logic          act_q, miss_q;
  logic [31:0]   idx_q;
  logic [CW-1:0] off_q;
  logic          is_last, take;

  assign is_last     = miss_q || (off_q == (count_i - CW'(1)));
  assign take        = !act_q || (en_i && is_last);
  assign res_ready_o = take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
      off_q <= '0;
    end else if (take) begin
      act_q <= res_valid_i;
      off_q <= '0;
    end else if (en_i) begin
      off_q <= off_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && res_valid_i) begin
      idx_q  <= res_i.index;
      miss_q <= res_i.missing;
    end
  end

  assign req_o.valid = act_q;
  assign req_o.key   = idx_q + 32'(off_q);
  assign req_o.last  = is_last;
  assign req_o.empty = miss_q;

endmodule

/* hw/rtl/hsse_hash.sv */
module hsse_hash #(
  parameter int unsigned MAX_SDR_SIZE = 65536
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  hsse_pkg::hash_req_t                 req_i,
  input  logic [31:0]                         seed_i,
  input  logic [$clog2(MAX_SDR_SIZE):0]       size_i,
  output logic                                vld_o,
  output logic [hsse_pkg::PosW-1:0]           pos_o,
  output logic                                last_o,
  output logic                                empty_o
);
  import hsse_pkg::*;

  localparam int unsigned SzW     = $clog2(MAX_SDR_SIZE) + 1;
  localparam int unsigned HashSt  = 6;
  localparam int unsigned ModBits = 4;
  localparam int unsigned ModSt   = 32 / ModBits;
  localparam int unsigned NumSt   = HashSt + ModSt;

  logic [NumSt-1:0] vld_q, lst_q, emp_q;
  logic [31:0]      h_q [NumSt-1];
  logic [31:0]      h_d [HashSt];
  logic [SzW-1:0]   rem_q [ModSt];
  logic [SzW-1:0]   rem_d [ModSt];
  logic [31:0]      x;

  // Murmur word mix and finalizer, at most one multiply per stage.
  always_comb begin
    h_d[0] = req_i.key * MurC1;
    h_d[1] = {h_q[0][16:0], h_q[0][31:17]} * MurC2;
    x      = seed_i ^ h_q[1];
    x      = {x[18:0], x[31:19]};
    x      = (x << 2) + x + MurAdd;
    x      = x ^ MurLen;
    h_d[2] = x ^ (x >> 16);
    h_d[3] = h_q[2] * MurFin1;
    h_d[4] = (h_q[3] ^ (h_q[3] >> 13)) * MurFin2;
    h_d[5] = h_q[4] ^ (h_q[4] >> 16);
  end

  // Remainder by restoring steps, four hash bits per stage, MSB first.
  for (genvar j = 0; j < ModSt; j++) begin : g_mod
    logic [SzW:0]   t;
    logic [SzW-1:0] r;
    always_comb begin
      r = (j == 0) ? '0 : rem_q[(j == 0) ? 0 : j-1];
      t = '0;
      for (int b = 0; b < ModBits; b++) begin
        t = {r, h_q[HashSt+j-1][31 - j*ModBits - b]};
        r = (t >= {1'b0, size_i}) ? SzW'(t - {1'b0, size_i}) : t[SzW-1:0];
      end
      rem_d[j] = r;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NumSt-2:0], req_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lst_q <= {lst_q[NumSt-2:0], req_i.last};
      emp_q <= {emp_q[NumSt-2:0], req_i.empty};
      for (int s = 0; s < HashSt; s++) begin
        h_q[s] <= h_d[s];
      end
      for (int s = HashSt; s < NumSt - 1; s++) begin
        h_q[s] <= h_q[s-1];
      end
      for (int s = 0; s < ModSt; s++) begin
        rem_q[s] <= rem_d[s];
      end
    end
  end

  logic [31:0] rem_ext;
  assign rem_ext = 32'(rem_q[ModSt-1]);

  assign vld_o   = vld_q[NumSt-1];
  assign pos_o   = rem_ext[PosW-1:0];
  assign last_o  = lst_q[NumSt-1];
  assign empty_o = emp_q[NumSt-1];

endmodule

/* hw/rtl/hashed_scalar_sparse_encoder.sv */
// Hashed scalar sparse encoder. Each input beat carries an unsigned Q32.16
// scalar and a missing flag. A present scalar is divided by the Q16.16
// resolution register to form a 32-bit bucket index, and the block then emits
// active_bits output beats, one per cycle while the output accepts them, each
// holding a MurmurHash3 (x86, 32-bit) of index+offset under hash_seed, reduced
// modulo sdr_size; the final beat of the group has last set. A missing scalar
// yields a single beat with empty_res and last set and bit position zero. Every
// accepted present scalar occupies the bucket divider from its accept through
// the quotient steps at two quotient bits per cycle; the hand-off of the result
// coincides with the accept of the next scalar, which the divider then works on
// while the previous group is emitted. The first output beat follows the
// divider's result through the hand-off register, a six-stage hash pipeline,
// an eight-stage remainder pipeline and the output register. Back-pressure on
// the output stalls the whole pipeline without losing or repeating beats.
// Configuration must only be written while the block is idle; out-of-range
// register values are clamped as zero-to-one and above-maximum-to-maximum, and
// a zero resolution is treated as one.
module hashed_scalar_sparse_encoder #(
  parameter int unsigned MAX_ACTIVE   = 64,
  parameter int unsigned MAX_SDR_SIZE = 65536
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  hsse_in_if.sink                        in_i,
  hsse_out_if.source                     out_o,
  input  logic                           cfg_we_i,
  input  logic [hsse_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [hsse_pkg::CfgDW-1:0]     cfg_data_i
);
  import hsse_pkg::*;

  localparam int unsigned CW  = $clog2(MAX_ACTIVE + 1);
  localparam int unsigned SzW = $clog2(MAX_SDR_SIZE) + 1;

  // Configuration registers.
  logic [16:0] sdr_size_q;
  logic [6:0]  active_bits_q;
  logic [31:0] resolution_q, seed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sdr_size_q    <= 17'd2048;
      active_bits_q <= 7'd21;
      resolution_q  <= 32'd65536;
      seed_q        <= 32'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegSdrSize:    sdr_size_q    <= cfg_data_i[16:0];
        RegActiveBits: active_bits_q <= cfg_data_i[6:0];
        RegResolution: resolution_q  <= cfg_data_i;
        RegHashSeed:   seed_q        <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamped working values; the user must keep them static while the block is busy, which the block does not enforce.
  logic [31:0]    sz32, cnt32, res_eff;
  logic [SzW-1:0] size_cl;
  logic [CW-1:0]  count_cl;

  always_comb begin
    sz32 = 32'(sdr_size_q);
    if (sz32 == 32'd0) begin
      sz32 = 32'd1;
    end else if (sz32 > 32'(MAX_SDR_SIZE)) begin
      sz32 = 32'(MAX_SDR_SIZE);
    end
    cnt32 = 32'(active_bits_q);
    if (cnt32 == 32'd0) begin
      cnt32 = 32'd1;
    end else if (cnt32 > 32'(MAX_ACTIVE)) begin
      cnt32 = 32'(MAX_ACTIVE);
    end
    res_eff = (resolution_q == 32'd0) ? 32'd1 : resolution_q;
  end

  assign size_cl  = sz32[SzW-1:0];
  assign count_cl = cnt32[CW-1:0];

  // Bucket divider, offset sequencer and hash pipeline.
  logic      div_vld, div_rdy;
  div_res_t  div_res;
  hash_req_t req;
  logic      en;
  logic      h_vld, h_last, h_empty;
  logic [PosW-1:0] h_pos;

  hsse_div u_div (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .resolution_i (res_eff),
    .res_valid_o  (div_vld),
    .res_o        (div_res),
    .res_ready_i  (div_rdy)
  );

  hsse_seq #(.MAX_ACTIVE(MAX_ACTIVE)) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (div_vld),
    .res_i       (div_res),
    .res_ready_o (div_rdy),
    .count_i     (count_cl),
    .en_i        (en),
    .req_o       (req)
  );

  hsse_hash #(.MAX_SDR_SIZE(MAX_SDR_SIZE)) u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .req_i   (req),
    .seed_i  (seed_q),
    .size_i  (size_cl),
    .vld_o   (h_vld),
    .pos_o   (h_pos),
    .last_o  (h_last),
    .empty_o (h_empty)
  );

  // Output register; the pipeline advances whenever it can move.
  logic            out_vld_q, out_last_q, out_empty_q;
  logic [PosW-1:0] out_pos_q;

  assign en = !out_vld_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= h_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_pos_q   <= h_empty ? '0 : h_pos;
      out_last_q  <= h_last;
      out_empty_q <= h_empty;
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.bit_position = out_pos_q;
  assign out_o.last         = out_last_q;
  assign out_o.empty_res    = out_empty_q;

  // An empty beat closes its group and carries no position.
  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.empty_res |-> out_o.last && (out_o.bit_position == '0))
    else $error("empty beat without last or with nonzero position");

  // A position always lies inside the pattern.
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.empty_res |-> (32'(out_o.bit_position) < sz32))
    else $error("bit position outside pattern size");

  // With a single active bit every beat ends its group.
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (count_cl == CW'(1)) |-> out_o.last)
    else $error("group of one without last");

endmodule

/* dv/hashed_scalar_sparse_encoder_tb.sv */
`timescale 1ns / 1ps

module hashed_scalar_sparse_encoder_tb;

  import hsse_pkg::*;

  localparam int unsigned MaxActive  = 64;
  localparam int unsigned MaxSdrSize = 65536;
  localparam int unsigned StallLimit = 20000;
  localparam int unsigned DrainCycles = 60;

  // One expected output beat.
  typedef struct {
    logic [PosW-1:0] bit_position;
    logic            last;
    logic            empty_res;
  } sdr_beat_t;

  // Scoreboard: keeps its own copy of the registers, predicts the active-bit
  // positions of each accepted scalar and compares output beats in order.
  class sdr_scoreboard;
    logic [16:0]     sdr_size;
    logic [6:0]      active_bits;
    logic [31:0]     resolution_q16;
    logic [31:0]     hash_seed;
    sdr_beat_t       pending_q[$];
    int unsigned     errors;

    function void reset_regs();
      sdr_size       = 17'd2048;
      active_bits    = 7'd21;
      resolution_q16 = 32'd65536;
      hash_seed      = 32'd1;
      errors         = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDW-1:0] data);
      case (idx)
        RegSdrSize:    sdr_size = data[16:0];
        RegActiveBits: active_bits = data[6:0];
        RegResolution: resolution_q16 = data;
        RegHashSeed:   hash_seed = data;
        default: ;
      endcase
    endfunction

    // MurmurHash3 x86 32-bit of a single 4-byte little-endian word.
    function logic [31:0] murmur_word(logic [31:0] key, logic [31:0] seed);
      logic [31:0] k;
      logic [31:0] h;
      k = key * MurC1;
      k = {k[16:0], k[31:17]};
      k = k * MurC2;
      h = seed ^ k;
      h = {h[18:0], h[31:19]};
      h = h * 32'd5 + MurAdd;
      h = h ^ MurLen;
      h = h ^ (h >> 16);
      h = h * MurFin1;
      h = h ^ (h >> 13);
      h = h * MurFin2;
      h = h ^ (h >> 16);
      return h;
    endfunction

    function void note_input(logic [ValW-1:0] value, logic missing);
      logic [63:0] res;
      logic [63:0] size;
      int unsigned count;
      logic [31:0] bucket;
      logic [63:0] quot;
      sdr_beat_t   beat;
      if (missing) begin
        beat.bit_position = '0;
        beat.last         = 1'b1;
        beat.empty_res    = 1'b1;
        pending_q.push_back(beat);
        return;
      end
      res  = (resolution_q16 == 0) ? 64'd1 : {32'd0, resolution_q16};
      size = (sdr_size == 0) ? 64'd1 : {47'd0, sdr_size};
      if (size > MaxSdrSize) size = MaxSdrSize;
      count = (active_bits == 0) ? 1 : active_bits;
      if (count > MaxActive) count = MaxActive;
      quot   = {16'd0, value} / res;
      bucket = quot[31:0];
      for (int unsigned i = 0; i < count; i++) begin
        beat.bit_position = 16'({32'd0, murmur_word(bucket + i, hash_seed)} % size);
        beat.last         = (i + 1 == count);
        beat.empty_res    = 1'b0;
        pending_q.push_back(beat);
      end
    endfunction

    function void check_beat(logic [PosW-1:0] pos, logic last, logic empty_res);
      sdr_beat_t exp_beat;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected beat pos=%0d last=%0b empty=%0b",
                 $time, pos, last, empty_res);
        errors++;
        return;
      end
      exp_beat = pending_q.pop_front();
      if (pos !== exp_beat.bit_position) begin
        $display("%0t: bit_position expected %0d actual %0d",
                 $time, exp_beat.bit_position, pos);
        errors++;
      end
      if (last !== exp_beat.last) begin
        $display("%0t: last expected %0b actual %0b", $time, exp_beat.last, last);
        errors++;
      end
      if (empty_res !== exp_beat.empty_res) begin
        $display("%0t: empty_res expected %0b actual %0b",
                 $time, exp_beat.empty_res, empty_res);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDW-1:0]    cfg_data_i;

  hsse_in_if  in_if ();
  hsse_out_if out_if ();

  hashed_scalar_sparse_encoder u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  sdr_scoreboard sb;

  // Idle percentages for the sender and the receiver, changed per phase.
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  // Cycles for which the receiver holds ready low regardless of its idle mix.
  int unsigned recv_hold;
  int unsigned quiet_cycles;

  initial begin
    clk_i = 1'b0;
  end
  always #10 clk_i = ~clk_i;

  // Receiver: decides ready anew at every rising edge. A requested hold-off
  // is counted down here so the sender keeps offering beats meanwhile.
  always @(posedge clk_i) begin
    if (recv_hold > 0) begin
      recv_hold <= recv_hold - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor and watchdog. Values sampled here are the ones from before the
  // edge, since all drivers update with nonblocking assignments.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) sb.note_input(in_if.value_q16, in_if.missing);
      if (out_if.valid && out_if.ready) begin
        sb.check_beat(out_if.bit_position, out_if.last, out_if.empty_res);
      end
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= StallLimit) begin
        $display("hashed_scalar_sparse_encoder verification failed");
        $finish;
      end
    end
  end

  // Leaves the write enable high; set_config drops it after its last write.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  task automatic set_config(logic [31:0] size, logic [31:0] count,
                            logic [31:0] res, logic [31:0] seed);
    write_reg(RegSdrSize, size);
    write_reg(RegActiveBits, count);
    write_reg(RegResolution, res);
    write_reg(RegHashSeed, seed);
    cfg_we_i <= 1'b0;
  endtask

  // Offers one scalar beat, optionally after random idle cycles, and returns
  // at the edge where it is accepted. Valid stays high into the next call.
  task automatic send_scalar(logic [ValW-1:0] value, logic missing);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.value_q16 <= value;
    in_if.missing   <= missing;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  // Waits until every predicted beat has been seen, then lets the pipeline
  // settle so that a register write lands on an idle block.
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic logic [ValW-1:0] rand_value();
    case ($urandom_range(3))
      0: return ValW'($urandom_range(255));
      1: return ValW'({$urandom_range(65535), 16'(0)} + $urandom_range(3) - 1);
      2: return ValW'($urandom);
      default: return {16'($urandom), 32'($urandom)};
    endcase
  endfunction

  task automatic random_scalars(int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      send_scalar(rand_value(), ($urandom_range(9) == 0));
    end
  endtask

  initial begin
    sb = new();
    sb.reset_regs();
    send_idle_pct   = 22;
    recv_idle_pct   = 53;
    recv_hold       = 0;
    quiet_cycles    = 0;
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = RegSdrSize;
    cfg_data_i      = '0;
    in_if.valid     = 1'b0;
    in_if.value_q16 = '0;
    in_if.missing   = 1'b0;
    out_if.ready    = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed beats under the reset configuration: field extremes, bucket
    // boundaries, and missing scalars carrying arbitrary values.
    send_scalar('0, 1'b0);
    send_scalar({ValW{1'b1}}, 1'b0);
    send_scalar(ValW'(65535), 1'b0);
    send_scalar(ValW'(65536), 1'b0);
    send_scalar(ValW'(131072), 1'b0);
    send_scalar('0, 1'b1);
    send_scalar({ValW{1'b1}}, 1'b1);
    send_scalar(48'h5555_5555_5555, 1'b0);
    send_scalar(48'haaaa_aaaa_aaaa, 1'b0);
    random_scalars(40);
    drain();

    // Tiny pattern, one bit, step of one so the bucket index wraps past
    // 2^32, and a zero seed. Midway the sender waits for a full drain.
    set_config(32'd1, 32'd1, 32'd1, 32'd0);
    send_scalar({ValW{1'b1}}, 1'b0);
    send_scalar(48'h0001_0000_0000, 1'b0);
    random_scalars(35);
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    random_scalars(35);
    drain();

    // Largest pattern and count with the widest step and an all-ones seed.
    // The receiver holds off for a long stretch so the block backs up.
    send_idle_pct = 53;
    recv_idle_pct = 22;
    set_config(32'd65536, 32'd64, 32'hffff_ffff, 32'hffff_ffff);
    send_scalar({ValW{1'b1}}, 1'b0);
    send_scalar(48'h0000_ffff_ffff, 1'b0);
    recv_hold = 400;
    random_scalars(50);
    drain();

    // Zero size, zero count and zero resolution behave as one.
    set_config(32'd0, 32'd0, 32'd0, $urandom);
    send_scalar({ValW{1'b1}}, 1'b0);
    random_scalars(60);
    drain();

    // Size and count above their maximum are clamped.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_config(32'h1_ffff, 32'h7f, $urandom_range(65536, 1), $urandom);
    random_scalars(40);
    drain();

    // Several random settings back to back, mostly with short groups.
    for (int p = 0; p < 4; p++) begin
      set_config($urandom_range(MaxSdrSize, 1), $urandom_range(24, 1),
                 $urandom, $urandom);
      random_scalars(44);
      drain();
    end

    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("hashed_scalar_sparse_encoder verification clean");
    end else begin
      $display("hashed_scalar_sparse_encoder verification failed");
    end
    $finish;
  end

endmodule
